// ----- src/hcmm_pkg.sv -----
// Shared types and constants for the handheld console memory map decoder.
// Used by the channel interfaces and by the top level; depends on nothing.

package hcmm_pkg;

   // Bus commands: bit 0 is the write flag, bit 1 the word flag
   localparam logic [1:0] CMD_READ_BYTE  = 2'd0;
   localparam logic [1:0] CMD_WRITE_BYTE = 2'd1;
   localparam logic [1:0] CMD_READ_WORD  = 2'd2;
   localparam logic [1:0] CMD_WRITE_WORD = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_WRAM_BANK   = 2'd0;
   localparam logic [1:0] CSR_VRAM_BANK   = 2'd1;
   localparam logic [1:0] CSR_NIBBLE_MODE = 2'd2;

   // Address map boundaries
   localparam logic [15:0] ADDR_ROMX       = 16'h4000;
   localparam logic [15:0] ADDR_VRAM       = 16'h8000;
   localparam logic [15:0] ADDR_CART_RAM   = 16'hA000;
   localparam logic [15:0] ADDR_WRAM0      = 16'hC000;
   localparam logic [15:0] ADDR_WRAMX      = 16'hD000;
   localparam logic [15:0] ADDR_ECHO       = 16'hE000;
   localparam logic [15:0] ADDR_OAM        = 16'hFE00;
   localparam logic [15:0] ADDR_UNUSABLE   = 16'hFEA0;
   localparam logic [15:0] ADDR_IO         = 16'hFF00;
   localparam logic [15:0] ADDR_HRAM       = 16'hFF80;
   localparam logic [15:0] ADDR_IE         = 16'hFFFF;
   localparam logic [15:0] ECHO_DISTANCE   = 16'h2000;

   // Data constants
   localparam logic [7:0] BYTE_LOCKED  = 8'hFF;
   localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
   localparam logic [7:0] IE_MASK      = 8'h1F;
   localparam logic [1:0] LCD_MODE_XFER = 2'd3;
   localparam logic [1:0] LCD_MODE_OAM  = 2'd2;

   // Fixed store sizes
   localparam int OAM_DEPTH  = 160;
   localparam int HRAM_DEPTH = 127;
   localparam int IE_W       = 5;

   typedef enum logic [2:0] {
      TGT_INTERNAL  = 3'd0,
      TGT_ROM0      = 3'd1,
      TGT_ROMX      = 3'd2,
      TGT_CART_RAM  = 3'd3,
      TGT_IO        = 3'd4,
      TGT_MBC_WRITE = 3'd5
   } target_type;

   typedef enum logic [3:0] {
      RGN_ROM,
      RGN_VRAM,
      RGN_CART_RAM,
      RGN_WRAM,
      RGN_OAM,
      RGN_UNUSABLE,
      RGN_IO,
      RGN_HRAM,
      RGN_IE
   } region_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] address;
      logic [15:0] write_data;
      logic [1:0]  lcd_mode;
      logic        lcd_enabled;
   } req_type;

   typedef struct packed {
      target_type  target;
      logic [15:0] ext_offset;
      logic        is_write;
      logic [7:0]  data;
      logic        locked;
      logic        last;
   } rsp_type;

   // One decoded byte access, carried from the memory cycle to the result cycle
   typedef struct packed {
      rsp_type    rsp;
      region_type region;
      logic       from_ram;
   } pend_type;

endpackage

// ----- src/hcmm_if.sv -----
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on hcmm_pkg for the target code type.

interface hcmm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] address;
   logic [15:0] write_data;
   logic [1:0]  lcd_mode;
   logic        lcd_enabled;

   modport source (output valid, cmd, address, write_data, lcd_mode, lcd_enabled,
                   input ready);
   modport sink   (input valid, cmd, address, write_data, lcd_mode, lcd_enabled,
                   output ready);
endinterface

interface hcmm_rsp_if;
   logic                 valid;
   logic                 ready;
   hcmm_pkg::target_type target;
   logic [15:0]          ext_offset;
   logic                 is_write;
   logic [7:0]           data;
   logic                 locked;
   logic                 last;

   modport source (output valid, target, ext_offset, is_write, data, locked, last,
                   input ready);
   modport sink   (input valid, target, ext_offset, is_write, data, locked, last,
                   output ready);
endinterface

interface hcmm_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] addr;
   logic [7:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

// ----- src/hcmm_ram.sv -----
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.

module hcmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable with the write flag, else capture read data; hold it between reads
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/handheld_console_memory_map.sv -----
// Top level of the handheld console memory map decoder.
// Depends on hcmm_pkg, the channel interfaces in hcmm_if and hcmm_ram.
//
//   channel   direction  transfer when           carries
//   req_ch    in         valid && ready          cmd, address, write_data, lcd_mode/enabled
//   rsp_ch    out        valid && ready          target, ext_offset, is_write, data, locked, last
//   csr_ch    in         valid && ready (ready=1) addr, wdata
//
// A byte access passes through accept, memory cycle and result cycle; a word access repeats the
// memory and result cycles for its high byte. Each byte goes through the single-port RAMs and
// then through their read register. After reset a clearing pass zeroes all RAMs; no request
// is taken meanwhile, register writes are. A result waits in the output register; the next
// request is accepted meanwhile, and the sequencer holds in its result cycle only while that
// register is still full.

module handheld_console_memory_map #(
   parameter int WRAM_BANKS = 8,
   parameter int VRAM_BANKS = 2
) (
   input  logic       clock,
   input  logic       reset,
   hcmm_req_if.sink   req_ch,
   hcmm_rsp_if.source rsp_ch,
   hcmm_csr_if.sink   csr_ch
);

   localparam int WRAM_DEPTH = WRAM_BANKS * 4096;
   localparam int VRAM_DEPTH = VRAM_BANKS * 8192;
   localparam int WRAM_AW    = $clog2(WRAM_DEPTH);
   localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
   localparam int OAM_AW     = $clog2(hcmm_pkg::OAM_DEPTH);
   localparam int HRAM_AW    = $clog2(hcmm_pkg::HRAM_DEPTH);
   localparam int CLR_DEPTH  = (WRAM_DEPTH > VRAM_DEPTH) ? WRAM_DEPTH : VRAM_DEPTH;
   localparam int CLR_W      = $clog2(CLR_DEPTH + 1);
   localparam logic [3:0] WRAM_BANKS_W = 4'(WRAM_BANKS);
   localparam logic       VRAM_SWITCH  = (VRAM_BANKS > 1);

   // Control state
   hcmm_pkg::state_type state_ff, state_in;
   logic [CLR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                byte_idx_ff, byte_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          wram_sel_ff, wram_sel_in;
   logic                vram_sel_ff, vram_sel_in;
   logic                nibble_ff, nibble_in;
   logic [hcmm_pkg::IE_W-1:0] irq_ff, irq_in;

   // Payload state
   hcmm_pkg::req_type   item_ff;
   hcmm_pkg::pend_type  pend_ff, dec;
   hcmm_pkg::rsp_type   rsp_ff, rsp_in;

   // Sequencer outputs
   logic req_ready, clearing, accessing, load_rsp, clr_done, word_more;
   logic csr_take;

   // Decode signals
   logic [15:0] byte_addr, map_addr;
   logic [7:0]  wr_byte;
   logic        wr, vlock, slock, mem_op;
   logic [14:0] wram_full;
   logic [13:0] vram_full;
   logic [3:0]  bank_calc;

   // RAM ports
   logic                  wram_en, vram_en, oam_en, hram_en, ram_we;
   logic [WRAM_AW-1:0]    wram_addr;
   logic [VRAM_AW-1:0]    vram_addr;
   logic [OAM_AW-1:0]     oam_addr;
   logic [HRAM_AW-1:0]    hram_addr;
   logic [7:0]            wram_wdata, ram_wdata;
   logic [7:0]            wram_rdata, vram_rdata, oam_rdata, hram_rdata;

   // Decode the current byte of the held request
   always_comb begin
      byte_addr = item_ff.address + 16'(byte_idx_ff);
      wr        = item_ff.cmd[0];
      wr_byte   = byte_idx_ff ? item_ff.write_data[15:8] : item_ff.write_data[7:0];
      vlock     = item_ff.lcd_enabled && (item_ff.lcd_mode == hcmm_pkg::LCD_MODE_XFER);
      slock     = item_ff.lcd_enabled && ((item_ff.lcd_mode == hcmm_pkg::LCD_MODE_XFER) ||
                                          (item_ff.lcd_mode == hcmm_pkg::LCD_MODE_OAM));
      if (byte_addr >= hcmm_pkg::ADDR_ECHO && byte_addr < hcmm_pkg::ADDR_OAM) begin
         map_addr = byte_addr - hcmm_pkg::ECHO_DISTANCE;
      end else begin
         map_addr = byte_addr;
      end

      dec.rsp.target     = hcmm_pkg::TGT_INTERNAL;
      dec.rsp.ext_offset = '0;
      dec.rsp.is_write   = wr;
      dec.rsp.data       = wr ? wr_byte : 8'h00;
      dec.rsp.locked     = 1'b0;
      dec.rsp.last       = !item_ff.cmd[1] || byte_idx_ff;
      dec.region         = hcmm_pkg::RGN_ROM;

      if (map_addr < hcmm_pkg::ADDR_VRAM) begin
         dec.region = hcmm_pkg::RGN_ROM;
         if (wr) begin
            dec.rsp.target     = hcmm_pkg::TGT_MBC_WRITE;
            dec.rsp.ext_offset = map_addr;
         end else if (map_addr < hcmm_pkg::ADDR_ROMX) begin
            dec.rsp.target     = hcmm_pkg::TGT_ROM0;
            dec.rsp.ext_offset = map_addr;
         end else begin
            dec.rsp.target     = hcmm_pkg::TGT_ROMX;
            dec.rsp.ext_offset = map_addr - hcmm_pkg::ADDR_ROMX;
         end
      end else if (map_addr < hcmm_pkg::ADDR_CART_RAM) begin
         dec.region     = hcmm_pkg::RGN_VRAM;
         dec.rsp.locked = vlock;
      end else if (map_addr < hcmm_pkg::ADDR_WRAM0) begin
         dec.region         = hcmm_pkg::RGN_CART_RAM;
         dec.rsp.target     = hcmm_pkg::TGT_CART_RAM;
         dec.rsp.ext_offset = map_addr;
      end else if (map_addr < hcmm_pkg::ADDR_ECHO) begin
         dec.region = hcmm_pkg::RGN_WRAM;
      end else if (map_addr < hcmm_pkg::ADDR_UNUSABLE) begin
         dec.region     = hcmm_pkg::RGN_OAM;
         dec.rsp.locked = slock;
      end else if (map_addr < hcmm_pkg::ADDR_IO) begin
         dec.region     = hcmm_pkg::RGN_UNUSABLE;
         dec.rsp.locked = 1'b1;
      end else if (map_addr < hcmm_pkg::ADDR_HRAM) begin
         dec.region         = hcmm_pkg::RGN_IO;
         dec.rsp.target     = hcmm_pkg::TGT_IO;
         dec.rsp.ext_offset = map_addr;
      end else if (map_addr < hcmm_pkg::ADDR_IE) begin
         dec.region = hcmm_pkg::RGN_HRAM;
      end else begin
         dec.region = hcmm_pkg::RGN_IE;
         if (!wr) begin
            dec.rsp.data = {3'b000, irq_ff};
         end
      end

      // Locked reads give all ones
      if (dec.rsp.locked && !wr) begin
         dec.rsp.data = hcmm_pkg::BYTE_LOCKED;
      end

      mem_op = !dec.rsp.locked && ((dec.region == hcmm_pkg::RGN_VRAM) ||
                                   (dec.region == hcmm_pkg::RGN_WRAM) ||
                                   (dec.region == hcmm_pkg::RGN_OAM)  ||
                                   (dec.region == hcmm_pkg::RGN_HRAM));
      dec.from_ram = mem_op && !wr;
   end

   // Form store indexes for the current byte
   always_comb begin
      if (map_addr < hcmm_pkg::ADDR_WRAMX) begin
         wram_full = {3'b000, map_addr[11:0]};
      end else begin
         wram_full = {wram_sel_ff, map_addr[11:0]};
      end
      vram_full = {vram_sel_ff, map_addr[12:0]};
   end

   // Drive the RAM ports: clearing pass or the decoded access
   always_comb begin
      wram_wdata = nibble_ff ? (wr_byte & hcmm_pkg::NIBBLE_MASK) : wr_byte;
      if (clearing) begin
         ram_we     = 1'b1;
         ram_wdata  = 8'h00;
         wram_wdata = 8'h00;
         wram_addr  = clr_cnt_ff[WRAM_AW-1:0];
         vram_addr  = clr_cnt_ff[VRAM_AW-1:0];
         oam_addr   = clr_cnt_ff[OAM_AW-1:0];
         hram_addr  = clr_cnt_ff[HRAM_AW-1:0];
         wram_en    = clr_cnt_ff < CLR_W'(WRAM_DEPTH);
         vram_en    = clr_cnt_ff < CLR_W'(VRAM_DEPTH);
         oam_en     = clr_cnt_ff < CLR_W'(hcmm_pkg::OAM_DEPTH);
         hram_en    = clr_cnt_ff < CLR_W'(hcmm_pkg::HRAM_DEPTH);
      end else begin
         ram_we     = wr;
         ram_wdata  = wr_byte;
         wram_addr  = wram_full[WRAM_AW-1:0];
         vram_addr  = vram_full[VRAM_AW-1:0];
         oam_addr   = map_addr[OAM_AW-1:0];
         hram_addr  = map_addr[HRAM_AW-1:0];
         wram_en    = accessing && mem_op && (dec.region == hcmm_pkg::RGN_WRAM);
         vram_en    = accessing && mem_op && (dec.region == hcmm_pkg::RGN_VRAM);
         oam_en     = accessing && mem_op && (dec.region == hcmm_pkg::RGN_OAM);
         hram_en    = accessing && mem_op && (dec.region == hcmm_pkg::RGN_HRAM);
      end
   end

   hcmm_ram #(.WIDTH(8), .DEPTH(WRAM_DEPTH)) u_wram (
      .clock (clock), .en (wram_en), .we (ram_we), .addr (wram_addr),
      .wdata (wram_wdata), .rdata (wram_rdata)
   );

   hcmm_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH)) u_vram (
      .clock (clock), .en (vram_en), .we (ram_we), .addr (vram_addr),
      .wdata (ram_wdata), .rdata (vram_rdata)
   );

   hcmm_ram #(.WIDTH(8), .DEPTH(hcmm_pkg::OAM_DEPTH)) u_oam (
      .clock (clock), .en (oam_en), .we (ram_we), .addr (oam_addr),
      .wdata (ram_wdata), .rdata (oam_rdata)
   );

   hcmm_ram #(.WIDTH(8), .DEPTH(hcmm_pkg::HRAM_DEPTH)) u_hram (
      .clock (clock), .en (hram_en), .we (ram_we), .addr (hram_addr),
      .wdata (ram_wdata), .rdata (hram_rdata)
   );

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      clearing  = 1'b0;
      accessing = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         hcmm_pkg::ST_CLEAR:  clearing  = 1'b1;
         hcmm_pkg::ST_IDLE:   req_ready = 1'b1;
         hcmm_pkg::ST_ACCESS: accessing = 1'b1;
         hcmm_pkg::ST_RESULT: load_rsp  = !rsp_valid_ff || rsp_ch.ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
      clr_done  = clr_cnt_ff == CLR_W'(CLR_DEPTH - 1);
      word_more = item_ff.cmd[1] && !byte_idx_ff;
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hcmm_pkg::ST_CLEAR: begin
            if (clr_done) state_in = hcmm_pkg::ST_IDLE;
         end
         hcmm_pkg::ST_IDLE: begin
            if (req_ch.valid) state_in = hcmm_pkg::ST_ACCESS;
         end
         hcmm_pkg::ST_ACCESS: begin
            state_in = hcmm_pkg::ST_RESULT;
         end
         hcmm_pkg::ST_RESULT: begin
            if (load_rsp) state_in = word_more ? hcmm_pkg::ST_ACCESS : hcmm_pkg::ST_IDLE;
         end
         default: begin
            state_in = hcmm_pkg::ST_IDLE;
         end
      endcase
   end

   // Counters, output valid and the byte index
   always_comb begin
      clr_cnt_in  = clearing ? clr_cnt_ff + CLR_W'(1) : clr_cnt_ff;
      byte_idx_in = byte_idx_ff;
      if (req_ch.valid && req_ready) begin
         byte_idx_in = 1'b0;
      end else if (load_rsp && word_more) begin
         byte_idx_in = 1'b1;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Register writes and the interrupt-enable store
   always_comb begin
      csr_take    = csr_ch.valid;
      wram_sel_in = wram_sel_ff;
      vram_sel_in = vram_sel_ff;
      nibble_in   = nibble_ff;
      irq_in      = irq_ff;
      // bank zero selects bank one, then fold into the bank count
      bank_calc = (csr_ch.wdata[2:0] == 3'd0) ? 4'd1 : {1'b0, csr_ch.wdata[2:0]};
      for (int i = 0; i < 3; i++) begin
         if (bank_calc >= WRAM_BANKS_W) bank_calc = bank_calc - WRAM_BANKS_W;
      end
      if (csr_take) begin
         case (csr_ch.addr)
            hcmm_pkg::CSR_WRAM_BANK:   wram_sel_in = bank_calc[2:0];
            hcmm_pkg::CSR_VRAM_BANK:   vram_sel_in = csr_ch.wdata[0] & VRAM_SWITCH;
            hcmm_pkg::CSR_NIBBLE_MODE: nibble_in   = csr_ch.wdata[0];
            default: begin
               nibble_in = nibble_ff;
            end
         endcase
      end
      if (accessing && wr && (dec.region == hcmm_pkg::RGN_IE)) begin
         irq_in = wr_byte[hcmm_pkg::IE_W-1:0] & hcmm_pkg::IE_MASK[hcmm_pkg::IE_W-1:0];
      end
   end

   // Build the result from the held decode and the RAM read data
   always_comb begin
      rsp_in = pend_ff.rsp;
      if (pend_ff.from_ram) begin
         case (pend_ff.region)
            hcmm_pkg::RGN_VRAM: rsp_in.data = vram_rdata;
            hcmm_pkg::RGN_WRAM: rsp_in.data = wram_rdata;
            hcmm_pkg::RGN_OAM:  rsp_in.data = oam_rdata;
            hcmm_pkg::RGN_HRAM: rsp_in.data = hram_rdata;
            default: begin
               rsp_in.data = pend_ff.rsp.data;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcmm_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         byte_idx_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wram_sel_ff  <= 3'd1;
         vram_sel_ff  <= 1'b0;
         nibble_ff    <= 1'b0;
         irq_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         byte_idx_ff  <= byte_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         wram_sel_ff  <= wram_sel_in;
         vram_sel_ff  <= vram_sel_in;
         nibble_ff    <= nibble_in;
         irq_ff       <= irq_in;
      end
   end

   // Payload registers: capture the request, the decode and the result
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ready) begin
         item_ff.cmd         <= req_ch.cmd;
         item_ff.address     <= req_ch.address;
         item_ff.write_data  <= req_ch.write_data;
         item_ff.lcd_mode    <= req_ch.lcd_mode;
         item_ff.lcd_enabled <= req_ch.lcd_enabled;
      end
      if (accessing) begin
         pend_ff <= dec;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ch.ready      = req_ready;
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.target     = rsp_ff.target;
   assign rsp_ch.ext_offset = rsp_ff.ext_offset;
   assign rsp_ch.is_write   = rsp_ff.is_write;
   assign rsp_ch.data       = rsp_ff.data;
   assign rsp_ch.locked     = rsp_ff.locked;
   assign rsp_ch.last       = rsp_ff.last;

`ifndef ASSERT_OFF
   // An accepted request starts on its low byte in the memory cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ready) |=> (state_ff == hcmm_pkg::ST_ACCESS) && !byte_idx_ff)
      else $error("accepted request did not start on its low byte");

   // The low byte of a word is followed by the high byte's memory cycle
   a_word_second: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && word_more) |=> (state_ff == hcmm_pkg::ST_ACCESS) && byte_idx_ff)
      else $error("word access lost its second byte");

   // Outside the clearing pass at most one store is touched per cycle
   a_one_store: assert property (@(posedge clock) disable iff (reset)
      !clearing |-> $onehot0({wram_en, vram_en, oam_en, hram_en}))
      else $error("more than one store accessed in a cycle");

   // Locked results are always internal
   a_locked_internal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.locked) |-> (rsp_ff.target == hcmm_pkg::TGT_INTERNAL))
      else $error("locked result carries an external target");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for handheld_console_memory_map: directed and random bus accesses
// are checked byte by byte against a behavioural memory map kept in the testbench.
// Depends on hcmm_pkg, the channel interfaces in hcmm_if and the RTL top level.

module tb;

   localparam logic [1:0] CSR_SPARE       = 2'd3;
   localparam logic [1:0] LCD_MODE_HBLANK = 2'd0;
   localparam logic [1:0] LCD_MODE_VBLANK = 2'd1;
   localparam int WRAM_BANK_COUNT = 8;
   localparam int VRAM_BANK_COUNT = 2;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 135;
   localparam int PRINT_LIMIT     = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hcmm_req_if req_ch();
   hcmm_rsp_if rsp_ch();
   hcmm_csr_if csr_ch();

   handheld_console_memory_map #(
      .WRAM_BANKS(WRAM_BANK_COUNT),
      .VRAM_BANKS(VRAM_BANK_COUNT)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // Mirror of the memories and bank registers
   logic [7:0] wram_mirror [WRAM_BANK_COUNT * 4096];
   logic [7:0] vram_mirror [VRAM_BANK_COUNT * 8192];
   logic [7:0] oam_mirror  [hcmm_pkg::OAM_DEPTH];
   logic [7:0] hram_mirror [hcmm_pkg::HRAM_DEPTH];
   logic [4:0] ie_mirror;
   logic [2:0] wram_bank_reg;
   logic       vram_bank_reg;
   logic       nibble_reg;

   hcmm_pkg::req_type bus_queue [$];
   hcmm_pkg::rsp_type expected_bytes [$];
   logic [15:0]       recent_addr [$];
   hcmm_pkg::req_type bus_item;
   int         unaccepted = 0;
   int         mismatches = 0;
   int         send_idle_pct = 14;
   int         recv_idle_pct = 62;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decode one byte of an access and update the mirror
   function automatic hcmm_pkg::rsp_type decode_byte(logic [15:0] addr_in, logic wr,
                                                     logic [7:0] val, logic [1:0] mode,
                                                     logic lcd_on, logic last_flag);
      hcmm_pkg::rsp_type r;
      logic [15:0] a;
      logic        vlock;
      logic        slock;
      int          idx;
      int          bank;
      a = addr_in;
      r.target = hcmm_pkg::TGT_INTERNAL;
      r.ext_offset = 16'h0000;
      r.is_write = wr;
      r.data = wr ? val : 8'h00;
      r.locked = 1'b0;
      r.last = last_flag;
      vlock = lcd_on && (mode == hcmm_pkg::LCD_MODE_XFER);
      slock = lcd_on && (mode == hcmm_pkg::LCD_MODE_XFER || mode == hcmm_pkg::LCD_MODE_OAM);
      // fold the echo region onto work RAM
      if (a >= hcmm_pkg::ADDR_ECHO && a < hcmm_pkg::ADDR_OAM)
         a = a - hcmm_pkg::ECHO_DISTANCE;
      if (a < hcmm_pkg::ADDR_VRAM) begin
         if (wr) begin
            r.target = hcmm_pkg::TGT_MBC_WRITE;
            r.ext_offset = a;
         end else if (a < hcmm_pkg::ADDR_ROMX) begin
            r.target = hcmm_pkg::TGT_ROM0;
            r.ext_offset = a;
         end else begin
            r.target = hcmm_pkg::TGT_ROMX;
            r.ext_offset = a - hcmm_pkg::ADDR_ROMX;
         end
      end else if (a < hcmm_pkg::ADDR_CART_RAM) begin
         if (vlock) begin
            r.locked = 1'b1;
            if (!wr) r.data = hcmm_pkg::BYTE_LOCKED;
         end else begin
            idx = (int'(vram_bank_reg) % VRAM_BANK_COUNT) * 8192
                  + int'(a - hcmm_pkg::ADDR_VRAM);
            if (wr) vram_mirror[idx] = val;
            else r.data = vram_mirror[idx];
         end
      end else if (a < hcmm_pkg::ADDR_WRAM0) begin
         r.target = hcmm_pkg::TGT_CART_RAM;
         r.ext_offset = a;
      end else if (a < hcmm_pkg::ADDR_ECHO) begin
         if (a < hcmm_pkg::ADDR_WRAMX) begin
            idx = int'(a - hcmm_pkg::ADDR_WRAM0);
         end else begin
            // bank zero selects bank one
            bank = (wram_bank_reg == 3'd0) ? 1 : int'(wram_bank_reg);
            bank = bank % WRAM_BANK_COUNT;
            idx = bank * 4096 + int'(a - hcmm_pkg::ADDR_WRAMX);
         end
         if (wr) wram_mirror[idx] = nibble_reg ? (val & hcmm_pkg::NIBBLE_MASK) : val;
         else r.data = wram_mirror[idx];
      end else if (a < hcmm_pkg::ADDR_UNUSABLE) begin
         if (slock) begin
            r.locked = 1'b1;
            if (!wr) r.data = hcmm_pkg::BYTE_LOCKED;
         end else begin
            idx = int'(a - hcmm_pkg::ADDR_OAM);
            if (wr) oam_mirror[idx] = val;
            else r.data = oam_mirror[idx];
         end
      end else if (a < hcmm_pkg::ADDR_IO) begin
         r.locked = 1'b1;
         if (!wr) r.data = hcmm_pkg::BYTE_LOCKED;
      end else if (a < hcmm_pkg::ADDR_HRAM) begin
         r.target = hcmm_pkg::TGT_IO;
         r.ext_offset = a;
      end else if (a < hcmm_pkg::ADDR_IE) begin
         idx = int'(a - hcmm_pkg::ADDR_HRAM);
         if (wr) hram_mirror[idx] = val;
         else r.data = hram_mirror[idx];
      end else begin
         if (wr) ie_mirror = val[4:0] & hcmm_pkg::IE_MASK[4:0];
         else r.data = {3'b000, ie_mirror};
      end
      return r;
   endfunction

   // Queue the byte results that one accepted access should produce
   task automatic predict_access(hcmm_pkg::req_type q);
      logic wr;
      logic word;
      wr = (q.cmd == hcmm_pkg::CMD_WRITE_BYTE || q.cmd == hcmm_pkg::CMD_WRITE_WORD);
      word = (q.cmd == hcmm_pkg::CMD_READ_WORD || q.cmd == hcmm_pkg::CMD_WRITE_WORD);
      expected_bytes.push_back(decode_byte(q.address, wr, q.write_data[7:0], q.lcd_mode,
                                           q.lcd_enabled, !word));
      if (word)
         expected_bytes.push_back(decode_byte(q.address + 16'd1, wr, q.write_data[15:8],
                                              q.lcd_mode, q.lcd_enabled, 1'b1));
   endtask

   task automatic report_mismatch(string what);
      // keep the log short when the block is badly broken
      if (mismatches < PRINT_LIMIT)
         $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   task automatic push_access(logic [1:0] cmd, logic [15:0] addr, logic [15:0] wdata,
                              logic [1:0] mode, logic lcd_on);
      hcmm_pkg::req_type q;
      q.cmd = cmd;
      q.address = addr;
      q.write_data = wdata;
      q.lcd_mode = mode;
      q.lcd_enabled = lcd_on;
      bus_queue.push_back(q);
      unaccepted++;
   endtask

   // Hold until every queued access has been taken and every byte result has come back
   task automatic wait_idle();
      while (unaccepted != 0 || expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= idx;
      csr_ch.wdata <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         hcmm_pkg::CSR_WRAM_BANK:   wram_bank_reg = val[2:0];
         hcmm_pkg::CSR_VRAM_BANK:   vram_bank_reg = val[0];
         hcmm_pkg::CSR_NIBBLE_MODE: nibble_reg = val[0];
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_config(logic [7:0] wram_val, logic [7:0] vram_val, logic [7:0] nib_val);
      write_csr(hcmm_pkg::CSR_WRAM_BANK, wram_val);
      write_csr(hcmm_pkg::CSR_VRAM_BANK, vram_val);
      write_csr(hcmm_pkg::CSR_NIBBLE_MODE, nib_val);
   endtask

   // Random accesses: mostly region-aimed, with reuse of written addresses for read-back
   task automatic run_random_phase(int count);
      logic [1:0]  cmd;
      logic [15:0] addr;
      logic [15:0] wdata;
      logic [1:0]  mode;
      logic        lcd_on;
      for (int n = 0; n < count; n++) begin
         cmd = 2'($urandom_range(0, 3));
         if (recent_addr.size() != 0 && $urandom_range(0, 99) < 45) begin
            addr = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
         end else begin
            case ($urandom_range(0, 11))
               0:  addr = 16'($urandom_range(0, 'h7FFF));
               1:  addr = 16'($urandom_range('h8000, 'h9FFF));
               2:  addr = 16'($urandom_range('hA000, 'hBFFF));
               3:  addr = 16'($urandom_range('hC000, 'hCFFF));
               4:  addr = 16'($urandom_range('hD000, 'hDFFF));
               5:  addr = 16'($urandom_range('hE000, 'hFDFF));
               6:  addr = 16'($urandom_range('hFE00, 'hFE9F));
               7:  addr = 16'($urandom_range('hFEA0, 'hFEFF));
               8:  addr = 16'($urandom_range('hFF00, 'hFF7F));
               9:  addr = 16'($urandom_range('hFF80, 'hFFFE));
               10: addr = hcmm_pkg::ADDR_IE;
               default: addr = 16'($urandom_range(0, 'hFFFF));
            endcase
         end
         wdata = 16'($urandom_range(0, 'hFFFF));
         mode = 2'($urandom_range(0, 3));
         lcd_on = ($urandom_range(0, 2) == 0);
         if (cmd == hcmm_pkg::CMD_WRITE_BYTE || cmd == hcmm_pkg::CMD_WRITE_WORD) begin
            recent_addr.push_back(addr);
            if (recent_addr.size() > 48)
               void'(recent_addr.pop_front());
         end
         push_access(cmd, addr, wdata, mode, lcd_on);
      end
   endtask

   // Drive requests from the pending queue; predict at each transfer
   always @(posedge clock) begin : bus_driver
      hcmm_pkg::req_type nxt;
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.cmd         <= hcmm_pkg::CMD_READ_BYTE;
         req_ch.address     <= 16'h0000;
         req_ch.write_data  <= 16'h0000;
         req_ch.lcd_mode    <= LCD_MODE_HBLANK;
         req_ch.lcd_enabled <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_access(bus_item);
            unaccepted--;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (bus_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = bus_queue.pop_front();
               bus_item           <= nxt;
               req_ch.cmd         <= nxt.cmd;
               req_ch.address     <= nxt.address;
               req_ch.write_data  <= nxt.write_data;
               req_ch.lcd_mode    <= nxt.lcd_mode;
               req_ch.lcd_enabled <= nxt.lcd_enabled;
               req_ch.valid       <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Stall the result channel at random and check each transfer against the oldest prediction
   always @(posedge clock) begin : result_monitor
      hcmm_pkg::rsp_type want;
      rsp_ch.ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, data %h", rsp_ch.data));
         end else begin
            want = expected_bytes.pop_front();
            check_field("target", rsp_ch.target, want.target);
            check_field("ext_offset", rsp_ch.ext_offset, want.ext_offset);
            check_field("is_write", rsp_ch.is_write, want.is_write);
            check_field("data", rsp_ch.data, want.data);
            check_field("locked", rsp_ch.locked, want.locked);
            check_field("last", rsp_ch.last, want.last);
         end
      end
   end

   initial begin : stimulus
      foreach (wram_mirror[i]) wram_mirror[i] = 8'h00;
      foreach (vram_mirror[i]) vram_mirror[i] = 8'h00;
      foreach (oam_mirror[i]) oam_mirror[i] = 8'h00;
      foreach (hram_mirror[i]) hram_mirror[i] = 8'h00;
      ie_mirror = 5'd0;
      wram_bank_reg = 3'd1;
      vram_bank_reg = 1'b0;
      nibble_reg = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.addr = hcmm_pkg::CSR_WRAM_BANK;
      csr_ch.wdata = 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: region edges, locks, echo, word wrap, reset bank settings
      push_access(hcmm_pkg::CMD_READ_BYTE,  16'h0000, 16'h0000, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_READ_BYTE,  16'h7FFF, 16'h0000, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_WRITE_BYTE, 16'h2000, 16'hFFFF, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_WRITE_WORD, 16'h8000, 16'hA55A, hcmm_pkg::LCD_MODE_XFER, 1'b0);
      push_access(hcmm_pkg::CMD_READ_WORD,  16'h8000, 16'h0000, hcmm_pkg::LCD_MODE_OAM,  1'b1);
      push_access(hcmm_pkg::CMD_WRITE_BYTE, 16'h9FFF, 16'h00C3, hcmm_pkg::LCD_MODE_XFER, 1'b1);
      push_access(hcmm_pkg::CMD_READ_BYTE,  16'h9FFF, 16'h0000, hcmm_pkg::LCD_MODE_XFER, 1'b1);
      push_access(hcmm_pkg::CMD_READ_BYTE,  16'h9FFF, 16'h0000, hcmm_pkg::LCD_MODE_XFER, 1'b0);
      push_access(hcmm_pkg::CMD_READ_WORD,  16'hBFFF, 16'h0000, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_WRITE_WORD, 16'hCFFF, 16'h1234, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_READ_WORD,  16'hEFFF, 16'h0000, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_WRITE_BYTE, 16'hFDFF, 16'h0077, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_READ_BYTE,  16'hDDFF, 16'h0000, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_WRITE_BYTE, 16'hFE00, 16'h0011, hcmm_pkg::LCD_MODE_OAM, 1'b1);
      push_access(hcmm_pkg::CMD_WRITE_BYTE, 16'hFE9F, 16'h0022, LCD_MODE_VBLANK, 1'b1);
      push_access(hcmm_pkg::CMD_READ_WORD,  16'hFE9F, 16'h0000, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_WRITE_BYTE, 16'hFEFF, 16'h0055, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_WRITE_WORD, 16'hFF7F, 16'hFFFF, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_WRITE_WORD, 16'hFFFE, 16'hFFFF, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_READ_WORD,  16'hFFFF, 16'h0000, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_READ_BYTE,  16'hFF00, 16'h0000, LCD_MODE_HBLANK, 1'b0);
      wait_idle();

      // Directed: bank zero, second video bank, nibble writes read back through the echo region
      set_config(8'h00, 8'hFF, 8'hFF);
      write_csr(CSR_SPARE, 8'hFF);
      push_access(hcmm_pkg::CMD_WRITE_BYTE, 16'hD000, 16'h00AB, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_READ_BYTE,  16'hF000, 16'h0000, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_WRITE_WORD, 16'h8000, 16'hFFFF, LCD_MODE_HBLANK, 1'b0);
      push_access(hcmm_pkg::CMD_READ_WORD,  16'h8000, 16'h0000, LCD_MODE_HBLANK, 1'b0);
      wait_idle();

      // Random phases; each waits for the block to drain before the next setting
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 3) begin
            send_idle_pct = 14;
            recv_idle_pct = 62;
         end else if (p < 6) begin
            send_idle_pct = 62;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (p)
            0: set_config(8'h07, 8'h00, 8'h00);
            1: set_config(8'hF8, 8'h01, 8'hFE);
            2: set_config(8'h01, 8'h00, 8'h01);
            default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)));
         endcase
         run_random_phase(PHASE_ITEMS);
         wait_idle();
      end

      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("PASS handheld_console_memory_map");
      else
         $display("FAIL handheld_console_memory_map");
      $finish;
   end

   // Give up well beyond the slowest legal run, clearing pass included
   initial begin : watchdog
      #4_000_000;
      $display("FAIL handheld_console_memory_map");
      $finish;
   end

endmodule
